>>> rtl/ctc_pkg.sv
`default_nettype none

package ctc_pkg;

  // field widths
  localparam int SCORE_W  = 16;
  localparam int CLASS_W  = 13;
  localparam int DICT_W   = 14;
  localparam int KEPT_W   = 11;
  localparam int TOTAL_W  = 26;

  // row position counter saturates at MAX_CLASSES, so it needs one more bit
  localparam int CNT_W       = CLASS_W + 1;
  localparam int MAX_CLASSES = 1 << CLASS_W;
  localparam int MAX_STEPS   = 1 << (KEPT_W - 1);

  // divider steps, one quotient bit each
  localparam int DIV_STEPS  = TOTAL_W;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  localparam logic [DICT_W-1:0] DICT_RESET = DICT_W'(MAX_CLASSES);

  // result kinds
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // request to the mean divider
  typedef struct packed {
    logic               start;
    logic               neg;
    logic [TOTAL_W-1:0] dividend;
    logic [KEPT_W-1:0]  divisor;
  } div_req_t;

endpackage

`default_nettype wire

>>> rtl/ctc_if.sv
`default_nettype none

// score input channel
interface ctc_in_if import ctc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] class_score;
  logic                      row_end;
  logic                      sequence_end;

  modport source (output valid, class_score, row_end, sequence_end, input ready);
  modport sink   (input valid, class_score, row_end, sequence_end, output ready);
endinterface

// result channel
interface ctc_out_if import ctc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [CLASS_W-1:0]        class_index;
  logic signed [SCORE_W-1:0] score_value;
  logic [KEPT_W-1:0]         kept_total;
  logic                      last_result;

  modport source (output valid, result_kind, class_index, score_value, kept_total,
                  last_result, input ready);
  modport sink   (input valid, result_kind, class_index, score_value, kept_total,
                  last_result, output ready);
endinterface

// configuration write channel
interface ctc_cfg_if import ctc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DICT_W-1:0] dictionary_size;

  modport source (output valid, dictionary_size, input ready);
  modport sink   (input valid, dictionary_size, output ready);
endinterface

`default_nettype wire

>>> rtl/ctc_greedy_decoder_unit.sv
`default_nettype none

// channel  dir  handshake      word
// in_ch    in   valid/ready    class_score, row_end, sequence_end
// out_ch   out  valid/ready    result_kind, class_index, score_value, kept_total, last_result
// cfg_ch   in   valid/ready    dictionary_size (always ready)
//
// A score is taken in any idle cycle with a free result register; a kept row winner
// is placed in the result register at the edge that takes the row's last score.
// A sequence end runs the restoring divider for the mean, 26 steps of one quotient bit,
// and no score is taken until the summary has been placed in the result register.
// Reset is synchronous, with no clearing pass.
// A full result register that is not being taken holds off the input and the summary.

module ctc_greedy_decoder_unit import ctc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  ctc_in_if.sink    in_ch,
  ctc_out_if.source out_ch,
  ctc_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_SUM  = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  logic [DICT_W-1:0]         dict_r;
  logic signed [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [CLASS_W-1:0]        best_class_r, best_class_nxt;
  logic [CNT_W-1:0]          cls_cnt_r, cls_cnt_nxt;
  logic [CLASS_W-1:0]        prev_win_r, prev_win_nxt;
  logic                      prev_valid_r, prev_valid_nxt;
  logic signed [TOTAL_W-1:0] total_r, total_nxt;
  logic [KEPT_W-1:0]         kept_cnt_r, kept_cnt_nxt;
  logic [KEPT_W-1:0]         sum_kept_r, sum_kept_nxt;
  logic signed [SCORE_W-1:0] mean_r, mean_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_kind_r, out_kind_nxt;
  logic [CLASS_W-1:0]        out_class_r, out_class_nxt;
  logic signed [SCORE_W-1:0] out_score_r, out_score_nxt;
  logic [KEPT_W-1:0]         out_kept_r, out_kept_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      out_free;
  logic                      in_acc;
  logic                      in_range;
  logic [CNT_W-1:0]          cls_cnt_inc;
  logic                      dup;
  logic                      keep;
  logic                      kept_full;
  logic signed [TOTAL_W-1:0] total_upd;
  logic [KEPT_W-1:0]         kept_upd;
  logic                      seq_close;
  div_req_t                  div_req;
  logic                      div_done;
  logic signed [SCORE_W-1:0] div_quo;

  // handshakes
  assign out_free     = ~out_valid_r | out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) & out_free;
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // running argmax, ties keep the earlier class
  assign in_range    = ~cls_cnt_r[CNT_W-1];
  assign cls_cnt_inc = in_range ? cls_cnt_r + 1'b1 : cls_cnt_r;

  always_comb begin
    best_score_nxt = best_score_r;
    best_class_nxt = best_class_r;
    if (cls_cnt_r == '0) begin
      best_score_nxt = in_ch.class_score;
      best_class_nxt = '0;
    end else if (in_range && (in_ch.class_score > best_score_r)) begin
      best_score_nxt = in_ch.class_score;
      best_class_nxt = cls_cnt_r[CLASS_W-1:0];
    end
  end

  // row close: drop blank, repeat or out-of-dictionary winner
  assign dup       = prev_valid_r & (best_class_nxt == prev_win_r);
  assign keep      = ~dup & (best_class_nxt != '0) & ({1'b0, best_class_nxt} < dict_r);
  assign kept_full = kept_cnt_r[KEPT_W-1];
  assign total_upd = (keep & ~kept_full)
                     ? total_r + TOTAL_W'(best_score_nxt) : total_r;
  assign kept_upd  = (keep & ~kept_full) ? kept_cnt_r + 1'b1 : kept_cnt_r;
  assign seq_close = in_acc & in_ch.row_end & in_ch.sequence_end;

  // mean divider request on the magnitude of the total
  always_comb begin
    div_req.start    = seq_close;
    div_req.neg      = total_upd[TOTAL_W-1];
    div_req.dividend = total_upd[TOTAL_W-1] ? TOTAL_W'(-total_upd) : TOTAL_W'(total_upd);
    div_req.divisor  = kept_upd;
  end

  ctc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer and decoder state
  always_comb begin
    state_nxt      = state_r;
    cls_cnt_nxt    = cls_cnt_r;
    prev_win_nxt   = prev_win_r;
    prev_valid_nxt = prev_valid_r;
    total_nxt      = total_r;
    kept_cnt_nxt   = kept_cnt_r;
    sum_kept_nxt   = sum_kept_r;
    mean_nxt       = mean_r;
    out_valid_nxt  = out_valid_r & ~out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_class_nxt  = out_class_r;
    out_score_nxt  = out_score_r;
    out_kept_nxt   = out_kept_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cls_cnt_nxt = cls_cnt_inc;
          if (in_ch.row_end) begin
            cls_cnt_nxt    = '0;
            prev_win_nxt   = best_class_nxt;
            prev_valid_nxt = 1'b1;
            total_nxt      = total_upd;
            kept_cnt_nxt   = kept_upd;
            if (keep) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_CHAR;
              out_class_nxt = best_class_nxt;
              out_score_nxt = best_score_nxt;
              out_kept_nxt  = kept_upd;
              out_last_nxt  = 1'b0;
            end
            if (in_ch.sequence_end) begin
              sum_kept_nxt   = kept_upd;
              prev_win_nxt   = '0;
              prev_valid_nxt = 1'b0;
              total_nxt      = '0;
              kept_cnt_nxt   = '0;
              state_nxt      = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mean_nxt  = div_quo;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SUMMARY;
          out_class_nxt = '0;
          out_score_nxt = mean_r;
          out_kept_nxt  = sum_kept_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dict_r       <= DICT_RESET;
      cls_cnt_r    <= '0;
      prev_win_r   <= '0;
      prev_valid_r <= 1'b0;
      total_r      <= '0;
      kept_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cls_cnt_r    <= cls_cnt_nxt;
      prev_win_r   <= prev_win_nxt;
      prev_valid_r <= prev_valid_nxt;
      total_r      <= total_nxt;
      kept_cnt_r   <= kept_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_ch.valid) begin
        dict_r <= cfg_ch.dictionary_size;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
    end
    sum_kept_r  <= sum_kept_nxt;
    mean_r      <= mean_nxt;
    out_kind_r  <= out_kind_nxt;
    out_class_r <= out_class_nxt;
    out_score_r <= out_score_nxt;
    out_kept_r  <= out_kept_nxt;
    out_last_r  <= out_last_nxt;
  end

  // result word
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.class_index = out_class_r;
  assign out_ch.score_value = out_score_r;
  assign out_ch.kept_total  = out_kept_r;
  assign out_ch.last_result = out_last_r;

  // a closed sequence leaves fresh tracking state and starts the divider
  a_seq_close: assert property (@(posedge clk) disable iff (!rst_n)
    seq_close |=> (kept_cnt_r == '0) && !prev_valid_r && (state_r == ST_DIV))
    else $error("sequence close did not clear tracking state");

  // the kept count never passes its ceiling
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_cnt_r <= KEPT_W'(MAX_STEPS))
    else $error("kept counter above ceiling");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done outside wait state");

  // no input word is taken while the summary is pending
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_SUM) |-> !in_ch.ready)
    else $error("input taken during summary");

endmodule

`default_nettype wire

>>> rtl/ctc_div.sv
`default_nettype none

module ctc_div import ctc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire div_req_t             req,
  output logic                      done,
  output logic signed [SCORE_W-1:0] quotient
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic [KEPT_W-1:0]     rem_r, rem_nxt;
  logic [TOTAL_W-1:0]    quo_r, quo_nxt;
  logic [KEPT_W-1:0]     dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic                  zero_r, zero_nxt;

  logic [KEPT_W+1:0]     trial;
  logic                  take;
  logic [SCORE_W:0]      q_mag;
  logic [SCORE_W:0]      q_signed;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign trial = {1'b0, rem_r, quo_r[TOTAL_W-1]} - {2'b00, dvs_r};
  assign take  = ~trial[KEPT_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      neg_nxt  = req.neg;
      zero_nxt = (req.divisor == '0);
    end else if (busy_r) begin
      rem_nxt  = take ? trial[KEPT_W-1:0] : {rem_r[KEPT_W-2:0], quo_r[TOTAL_W-1]};
      quo_nxt  = {quo_r[TOTAL_W-2:0], take};
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  // magnitude never exceeds 2^(SCORE_W-1), sign applied last
  assign q_mag    = quo_r[SCORE_W:0];
  assign q_signed = neg_r ? (~q_mag + 1'b1) : q_mag;
  assign quotient = zero_r ? '0 : q_signed[SCORE_W-1:0];
  assign done     = done_r;

endmodule

`default_nettype wire
